### src/scli_pkg.sv
// shared types and constants for the scalar colour lookup interpolator
package scli_pkg;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MIN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT  = 2'd3;

    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_WRITE  = 1'b1;

    localparam int CHAN_W   = 16;
    localparam int NUM_CHAN = 4;
    localparam int ENTRY_W  = CHAN_W * NUM_CHAN;
    localparam int WEIGHT_W = CHAN_W + 1;
    localparam int ACC_W    = 2 * CHAN_W;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;
    localparam logic [ACC_W-1:0]    ROUND_HALF = 32'h0000_8000;

    localparam logic signed [31:0] RANGE_MIN_RST    = 32'sd0;
    localparam logic signed [31:0] RANGE_MAX_RST    = 32'sd65536;
    localparam logic [31:0]        SCALE_FACTOR_RST = 32'd16711680;
    localparam logic [8:0]         ENTRY_COUNT_RST  = 9'd256;

    // channel 0 red, 1 green, 2 blue, 3 alpha
    typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] rgba_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_MUL,
        ST_ADDR,
        ST_INTERP,
        ST_OUT
    } scli_state_t;

endpackage

### src/scli_ram.sv
// generic single write port, single read port ram with registered read
module scli_ram #(
    parameter int DATA_W = 64,
    parameter int DEPTH  = 128,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/scalar_color_lut_interp.sv
// top level: scalar to rgba colour lookup with linear interpolation
//
//  channel   direction  handshake        payload
//  s_*       in         s_valid/s_ready  s_mode, s_scalar, s_entry_index, s_*_in
//  m_*       out        m_valid/m_ready  m_red_out, m_green_out, m_blue_out, m_alpha_out
//  cfg_*     in         cfg_we only      cfg_index, cfg_wdata
//
// a table write leaves the sequencer idle and s_ready stays high
// a lookup holds the input side from acceptance to the next acceptance:
//   difference, 32x32 multiply, address and ram read, interpolate, output (which
//   may wait for the output register), then idle again
// the table sits in two rams with registered read (even and odd entries) so both
//   neighbours come back in the same read cycle
// reset clears control and configuration; table contents stay unknown until written
// a result waiting on m_ready does not block new transactions; only the final
//   output step of the next lookup waits for the output register to free up
module scalar_color_lut_interp #(
    parameter int MAX_ENTRIES = 256
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           cfg_we,
    input  logic [scli_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_wdata,

    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_mode,
    input  logic signed [31:0]             s_scalar,
    input  logic [7:0]                     s_entry_index,
    input  logic [15:0]                    s_red_in,
    input  logic [15:0]                    s_green_in,
    input  logic [15:0]                    s_blue_in,
    input  logic [15:0]                    s_alpha_in,

    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [15:0]                    m_red_out,
    output logic [15:0]                    m_green_out,
    output logic [15:0]                    m_blue_out,
    output logic [15:0]                    m_alpha_out
);

    import scli_pkg::*;

    localparam int IDX_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W      = $clog2(MAX_ENTRIES + 1);
    localparam int BANK_DEPTH = (MAX_ENTRIES + 1) / 2;
    localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    // configuration registers
    logic signed [31:0] range_min_reg;
    logic signed [31:0] range_max_reg;
    logic [31:0]        scale_factor_reg;
    logic [8:0]         entry_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_min_reg    <= RANGE_MIN_RST;
            range_max_reg    <= RANGE_MAX_RST;
            scale_factor_reg <= SCALE_FACTOR_RST;
            entry_count_reg  <= ENTRY_COUNT_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_RANGE_MIN:    range_min_reg    <= cfg_wdata;
                CFG_RANGE_MAX:    range_max_reg    <= cfg_wdata;
                CFG_SCALE_FACTOR: scale_factor_reg <= cfg_wdata;
                CFG_ENTRY_COUNT:  entry_count_reg  <= cfg_wdata[8:0];
                default: ;
            endcase
        end
    end

    // entries in use, clamped to 2..MAX_ENTRIES
    logic [CNT_W-1:0] count_use;
    logic [31:0]      count_wide;

    always_comb begin
        if (entry_count_reg < 9'd2) begin
            count_use = CNT_W'(2);
        end else if (32'(entry_count_reg) > 32'(MAX_ENTRIES)) begin
            count_use = CNT_W'(MAX_ENTRIES);
        end else begin
            count_use = CNT_W'(entry_count_reg);
        end
        count_wide = 32'(count_use);
    end

    // sequencer
    scli_state_t state_reg;
    scli_state_t state_next;
    logic        m_valid_reg;
    logic        s_accept;
    logic        out_load;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && s_mode == MODE_LOOKUP) begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:   state_next = ST_MUL;
            ST_MUL:    state_next = ST_ADDR;
            ST_ADDR:   state_next = ST_INTERP;
            ST_INTERP: state_next = ST_OUT;
            ST_OUT: begin
                // output register free, or being emptied this cycle
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // table write straight from the accepted transaction, split by index parity
    logic               tbl_we;
    logic               we_even;
    logic               we_odd;
    logic [BANK_AW-1:0] waddr;
    rgba_t              wentry;

    assign tbl_we  = s_accept && (s_mode == MODE_WRITE)
                     && (32'(s_entry_index) < 32'(MAX_ENTRIES));
    assign we_even = tbl_we && !s_entry_index[0];
    assign we_odd  = tbl_we && s_entry_index[0];
    assign waddr   = BANK_AW'(s_entry_index >> 1);
    assign wentry  = {s_alpha_in, s_blue_in, s_green_in, s_red_in};

    // difference stage: clamp tests and offset from range_min
    logic signed [31:0] scalar_reg;
    logic               sat_lo_reg;
    logic               sat_hi_reg;
    logic [31:0]        diff_reg;
    logic [63:0]        pos_reg;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            scalar_reg <= s_scalar;
        end
        if (state_reg == ST_DIFF) begin
            sat_lo_reg <= (scalar_reg <= range_min_reg);
            sat_hi_reg <= (scalar_reg >= range_max_reg);
            // only used when min < scalar < max, so it fits 32 bits unsigned
            diff_reg   <= 32'(scalar_reg - range_min_reg);
        end
        if (state_reg == ST_MUL) begin
            pos_reg <= 64'(diff_reg) * 64'(scale_factor_reg);
        end
    end

    // address stage: base entry and weight from the q32.32 position
    logic [IDX_W-1:0]    base_next;
    logic [WEIGHT_W-1:0] weight_next;
    logic [IDX_W-1:0]    base_reg;
    logic [WEIGHT_W-1:0] weight_reg;
    logic [BANK_AW-1:0]  base_half;
    logic [BANK_AW-1:0]  raddr_even;
    logic [BANK_AW-1:0]  raddr_odd;

    always_comb begin
        if (sat_lo_reg) begin
            base_next   = '0;
            weight_next = '0;
        end else if (sat_hi_reg || (pos_reg[63:32] >= count_wide - 32'd1)) begin
            // top of range or index overflow: last entry in use
            base_next   = IDX_W'(count_wide - 32'd2);
            weight_next = WEIGHT_ONE;
        end else begin
            base_next   = pos_reg[32 +: IDX_W];
            weight_next = {1'b0, pos_reg[31:16]};
        end
    end

    // an odd base takes its upper neighbour from the next even row
    assign base_half  = BANK_AW'(base_next >> 1);
    assign raddr_odd  = base_half;
    assign raddr_even = base_half + BANK_AW'(base_next[0]);

    always_ff @(posedge aclk) begin
        if (state_reg == ST_ADDR) begin
            base_reg   <= base_next;
            weight_reg <= weight_next;
        end
    end

    logic [ENTRY_W-1:0] rdata_even;
    logic [ENTRY_W-1:0] rdata_odd;

    scli_ram #(
        .DATA_W (ENTRY_W),
        .DEPTH  (BANK_DEPTH)
    ) u_ram_even (
        .aclk  (aclk),
        .we    (we_even),
        .waddr (waddr),
        .wdata (wentry),
        .raddr (raddr_even),
        .rdata (rdata_even)
    );

    scli_ram #(
        .DATA_W (ENTRY_W),
        .DEPTH  (BANK_DEPTH)
    ) u_ram_odd (
        .aclk  (aclk),
        .we    (we_odd),
        .waddr (waddr),
        .wdata (wentry),
        .raddr (raddr_odd),
        .rdata (rdata_odd)
    );

    // interpolation stage: a*(1-w) + b*w + half, per channel
    rgba_t                          lo_entry;
    rgba_t                          hi_entry;
    logic [WEIGHT_W-1:0]            weight_inv;
    logic [NUM_CHAN-1:0][ACC_W-1:0] acc_next;
    logic [NUM_CHAN-1:0][ACC_W-1:0] acc_reg;

    always_comb begin
        lo_entry   = base_reg[0] ? rgba_t'(rdata_odd)  : rgba_t'(rdata_even);
        hi_entry   = base_reg[0] ? rgba_t'(rdata_even) : rgba_t'(rdata_odd);
        weight_inv = WEIGHT_ONE - weight_reg;
        for (int k = 0; k < NUM_CHAN; k++) begin
            // peak is 65535 * 65536 + 32768, below 2^32
            acc_next[k] = ACC_W'(33'(lo_entry[k]) * 33'(weight_inv)
                                 + 33'(hi_entry[k]) * 33'(weight_reg)
                                 + 33'(ROUND_HALF));
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_INTERP) begin
            acc_reg <= acc_next;
        end
    end

    // output register
    rgba_t out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            for (int k = 0; k < NUM_CHAN; k++) begin
                out_reg[k] <= acc_reg[k][ACC_W-1:CHAN_W];
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_red_out   = out_reg[0];
    assign m_green_out = out_reg[1];
    assign m_blue_out  = out_reg[2];
    assign m_alpha_out = out_reg[3];

    // a lookup reaches the output step through the difference, multiply, address and interpolate states, with no stall
    a_lookup_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_mode == MODE_LOOKUP) |-> ##5 (state_reg == ST_OUT))
        else $error("lookup did not reach output step on time");

    // base never points past the second-to-last entry in use
    a_base_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_INTERP) |-> (32'(base_reg) <= count_wide - 32'd2))
        else $error("interpolation base beyond table");

    // full weight carries no fraction
    a_weight_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_INTERP && weight_reg[WEIGHT_W-1]) |->
        (weight_reg[WEIGHT_W-2:0] == '0))
        else $error("interpolation weight above one");

    // results only appear from the output step
    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside output step");

    // no table write while a lookup is in flight
    a_no_write_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (we_even || we_odd) |-> (state_reg == ST_IDLE))
        else $error("table written during lookup");

endmodule
